@@ rtl/ordered_list_manager_core_defines.svh @@
// ============================================================================
// Ordered list manager assertion macros
// Shared concurrent assertion forms, clocked on aclk and quiet in reset.
// ============================================================================
`ifndef ORDERED_LIST_MANAGER_CORE_DEFINES_SVH
`define ORDERED_LIST_MANAGER_CORE_DEFINES_SVH

// A condition that must hold at every clock edge.
`define OLM_ASSERT_ALWAYS(lbl, cond, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (cond)) else $error(msg);

// A condition that must hold whenever the antecedent holds.
`define OLM_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

`endif

@@ rtl/olm_pkg.sv @@
// ============================================================================
// Ordered list manager package
// Command kinds, status codes, controller states and the command and status
// bundles between the controller and the datapath.
// ============================================================================
package olm_pkg;

    localparam int DEF_CAPACITY = 32;
    localparam int MAX_RESULTS  = 32;
    localparam int NRES_W       = 6;
    localparam int POS_W        = 8;
    localparam int VAL_W        = 32;
    localparam int OUT_CNT_W    = 6;

    typedef enum logic [3:0] {
        K_APPEND    = 4'd0,
        K_PREPEND   = 4'd1,
        K_INSERT_AT = 4'd2,
        K_DEL_LAST  = 4'd3,
        K_DEL_FIRST = 4'd4,
        K_DEL_AT    = 4'd5,
        K_DEL_VALUE = 4'd6,
        K_SEARCH    = 4'd7,
        K_DUMP      = 4'd8
    } kind_t;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_EMPTY    = 3'd1,
        ST_BADPOS   = 3'd2,
        ST_NOTFOUND = 3'd3,
        ST_FULL     = 3'd4
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE, S_DECODE, S_RESP, S_INS_CHK, S_INS_WR, S_REM_CHK, S_REM_WR,
        S_DV_RD, S_DV_CMP, S_SR_RD, S_SR_CMP, S_SR_FIN, S_DP_RD, S_DP_OUT
    } state_t;

    typedef enum logic [2:0] {
        IDX_HOLD, IDX_FILL, IDX_ZERO, IDX_POS, IDX_INC, IDX_DEC
    } idx_op_t;

    typedef enum logic [1:0] {TGT_HOLD, TGT_FILL, TGT_ZERO, TGT_POS} tgt_op_t;
    typedef enum logic [1:0] {RD_IDX, RD_PREV, RD_NEXT} rd_sel_t;
    typedef enum logic {WR_SHIFT, WR_NEW} wr_sel_t;
    typedef enum logic [1:0] {FILL_HOLD, FILL_INC, FILL_DEC} fill_op_t;
    typedef enum logic [1:0] {EM_NONE, EM_CODE, EM_PEND, EM_DUMP} emit_t;

    typedef struct packed {
        logic     load;
        idx_op_t  idx_op;
        tgt_op_t  tgt_op;
        logic     rd_en;
        rd_sel_t  rd_sel;
        logic     wr_en;
        wr_sel_t  wr_sel;
        fill_op_t fill_op;
        logic     set_code;
        status_t  code;
        logic     pend_set;
        logic     pend_clr;
        logic     nres_clr;
        emit_t    emit;
        logic     emit_last;
    } olm_cmd_t;

    typedef struct packed {
        kind_t kind;
        logic  empty;
        logic  full;
        logic  badpos_ins;
        logic  badpos_del;
        logic  idx_gt_tgt;
        logic  rem_more;
        logic  idx_at_end;
        logic  match;
        logic  pend_valid;
        logic  cap;
        logic  out_free;
        logic  dump_end;
    } olm_stat_t;

endpackage

@@ rtl/ordered_list_manager_core.sv @@
// ============================================================================
// Ordered list manager core
// Keeps an ordered list of signed 32-bit values under streamed requests.
// ============================================================================
// One request is worked at a time. Each entry that is moved, compared or
// dumped is first read from the element store into a register and then
// written, tested or sent on, in a separate controller state. Requests whose
// results are several (search, dump) give one result per match or entry,
// the final one with tlast set, and at most 32 of them. No clearing pass is
// needed after reset.
module ordered_list_manager_core
    import olm_pkg::*;
#(
    parameter int CAPACITY = DEF_CAPACITY
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // position[7:0], item_value[39:8]
    input  logic [3:0]  s_tuser,   // kind[3:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // found_position[5:0], entry_value[37:6],
                                   // list_length[43:38], zeros above
    output logic [2:0]  m_tuser,   // status[2:0]
    output logic        m_tlast
);

    olm_cmd_t  cmd;
    olm_stat_t stat;

    olm_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    olm_datapath #(
        .CAPACITY (CAPACITY)
    ) u_datapath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tready (m_tready),
        .m_tvalid (m_tvalid),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast),
        .cmd      (cmd),
        .stat     (stat)
    );

endmodule

@@ rtl/olm_datapath.sv @@
// ============================================================================
// Ordered list manager datapath
// Element store, fill level, scan index, compare and the result register.
// ============================================================================
`include "ordered_list_manager_core_defines.svh"

module olm_datapath
    import olm_pkg::*;
#(
    parameter int CAPACITY = DEF_CAPACITY
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_tvalid,
    input  logic [39:0]      s_tdata,
    input  logic [3:0]       s_tuser,
    input  logic             m_tready,
    output logic             m_tvalid,
    output logic [47:0]      m_tdata,
    output logic [2:0]       m_tuser,
    output logic             m_tlast,
    input  olm_cmd_t         cmd,
    output olm_stat_t        stat
);

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int AW = $clog2(CAPACITY);

    logic [VAL_W-1:0] mem [CAPACITY];

    kind_t             kind_reg;
    logic [POS_W-1:0]  pos_reg;
    logic [VAL_W-1:0]  val_reg;
    logic [CW-1:0]     fill_reg, idx_reg, idx_next, tgt_reg, pend_reg;
    logic              pend_valid_reg;
    logic [NRES_W-1:0] nres_reg;
    logic [VAL_W-1:0]  rd_data_reg;
    status_t           code_reg;

    logic              out_valid_reg;
    status_t           out_status_reg;
    logic [OUT_CNT_W-1:0] out_pos_reg, out_len_reg;
    logic [VAL_W-1:0]  out_val_reg;
    logic              out_last_reg;

    logic [CW-1:0]     rd_idx;
    logic [CW:0]       idx_plus1, fill_plus1;
    logic [POS_W:0]    pos_ext;
    logic              out_free;

    assign idx_plus1  = {1'b0, idx_reg} + 1'b1;
    assign fill_plus1 = {1'b0, fill_reg} + 1'b1;
    assign pos_ext    = {1'b0, pos_reg};
    assign out_free   = !out_valid_reg || m_tready;

    always_comb begin
        case (cmd.rd_sel)
            RD_PREV: rd_idx = idx_reg - 1'b1;
            RD_NEXT: rd_idx = idx_plus1[CW-1:0];
            default: rd_idx = idx_reg;
        endcase
    end

    always_comb begin
        case (cmd.idx_op)
            IDX_FILL: idx_next = fill_reg;
            IDX_ZERO: idx_next = '0;
            IDX_POS:  idx_next = CW'(pos_reg - 1'b1);
            IDX_INC:  idx_next = idx_plus1[CW-1:0];
            IDX_DEC:  idx_next = idx_reg - 1'b1;
            default:  idx_next = idx_reg;
        endcase
    end

    // Store: one write and one registered read per cycle.
    always_ff @(posedge aclk) begin
        if (cmd.wr_en) begin
            if (cmd.wr_sel == WR_NEW) begin
                mem[tgt_reg[AW-1:0]] <= val_reg;
            end else begin
                mem[idx_reg[AW-1:0]] <= rd_data_reg;
            end
        end
        if (cmd.rd_en) begin
            rd_data_reg <= mem[rd_idx[AW-1:0]];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            kind_reg <= kind_t'(s_tuser);
            pos_reg  <= s_tdata[POS_W-1:0];
            val_reg  <= s_tdata[POS_W +: VAL_W];
        end
        idx_reg <= idx_next;
        case (cmd.tgt_op)
            TGT_FILL: tgt_reg <= fill_reg;
            TGT_ZERO: tgt_reg <= '0;
            TGT_POS:  tgt_reg <= CW'(pos_reg - 1'b1);
            default:  tgt_reg <= tgt_reg;
        endcase
        if (cmd.set_code) begin
            code_reg <= cmd.code;
        end
        if (cmd.pend_set) begin
            pend_reg <= idx_plus1[CW-1:0];
        end
        if (cmd.emit != EM_NONE) begin
            out_status_reg <= (cmd.emit == EM_CODE) ? code_reg : ST_OK;
            out_last_reg   <= cmd.emit_last;
            out_len_reg    <= OUT_CNT_W'(fill_reg);
            case (cmd.emit)
                EM_PEND: begin
                    out_pos_reg <= OUT_CNT_W'(pend_reg);
                    out_val_reg <= '0;
                end
                EM_DUMP: begin
                    out_pos_reg <= OUT_CNT_W'(idx_plus1);
                    out_val_reg <= rd_data_reg;
                end
                default: begin
                    out_pos_reg <= '0;
                    out_val_reg <= '0;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_reg       <= '0;
            pend_valid_reg <= 1'b0;
            nres_reg       <= '0;
            out_valid_reg  <= 1'b0;
        end else begin
            case (cmd.fill_op)
                FILL_INC: fill_reg <= fill_reg + 1'b1;
                FILL_DEC: fill_reg <= fill_reg - 1'b1;
                default:  fill_reg <= fill_reg;
            endcase
            if (cmd.pend_clr) begin
                pend_valid_reg <= 1'b0;
            end else if (cmd.pend_set) begin
                pend_valid_reg <= 1'b1;
            end
            if (cmd.nres_clr) begin
                nres_reg <= '0;
            end else if (cmd.emit == EM_PEND || cmd.emit == EM_DUMP) begin
                nres_reg <= nres_reg + 1'b1;
            end
            if (cmd.emit != EM_NONE) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_comb begin
        stat.kind       = kind_reg;
        stat.empty      = (fill_reg == '0);
        stat.full       = (fill_reg == CW'(CAPACITY));
        stat.badpos_ins = (pos_reg == '0) || (pos_ext > (POS_W+1)'(fill_plus1));
        stat.badpos_del = (pos_reg == '0) || (pos_ext > (POS_W+1)'(fill_reg));
        stat.idx_gt_tgt = (idx_reg > tgt_reg);
        stat.rem_more   = (idx_plus1 < {1'b0, fill_reg});
        stat.idx_at_end = (idx_reg == fill_reg);
        stat.match      = (rd_data_reg == val_reg);
        stat.pend_valid = pend_valid_reg;
        stat.cap        = (nres_reg == NRES_W'(MAX_RESULTS - 1));
        stat.out_free   = out_free;
        stat.dump_end   = (idx_plus1 == {1'b0, fill_reg}) ||
                          (nres_reg == NRES_W'(MAX_RESULTS - 1));
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'b0, out_len_reg, out_val_reg, out_pos_reg};
    assign m_tuser  = out_status_reg;
    assign m_tlast  = out_last_reg;

    `OLM_ASSERT_ALWAYS(a_fill_bound, fill_reg <= CW'(CAPACITY), "fill level above capacity")
    `OLM_ASSERT_IMPL(a_emit_free, cmd.emit != EM_NONE, out_free, "result overwritten")
    `OLM_ASSERT_IMPL(a_grow_room, cmd.fill_op == FILL_INC, fill_reg < CW'(CAPACITY),
        "insert into full list")
    `OLM_ASSERT_IMPL(a_load_valid, cmd.load, s_tvalid, "request loaded without valid")

endmodule

@@ rtl/olm_ctrl.sv @@
// ============================================================================
// Ordered list manager controller
// Sequences each request through the checks, shifts, scans and results.
// ============================================================================
module olm_ctrl
    import olm_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_tvalid,
    output logic      s_tready,
    input  olm_stat_t stat,
    output olm_cmd_t  cmd
);

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        s_tready   = 1'b0;
        cmd        = '0;
        cmd.idx_op = IDX_HOLD;
        cmd.tgt_op = TGT_HOLD;
        cmd.rd_sel = RD_IDX;
        cmd.wr_sel = WR_SHIFT;
        cmd.fill_op = FILL_HOLD;
        cmd.code   = ST_OK;
        cmd.emit   = EM_NONE;

        unique case (state_reg)
            S_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    state_next = S_DECODE;
                end
            end
            S_DECODE: begin
                cmd.set_code = 1'b1;
                state_next   = S_RESP;
                unique case (stat.kind)
                    K_APPEND, K_PREPEND: begin
                        if (stat.full) begin
                            cmd.code = ST_FULL;
                        end else begin
                            cmd.tgt_op = (stat.kind == K_APPEND) ? TGT_FILL : TGT_ZERO;
                            cmd.idx_op = IDX_FILL;
                            state_next = S_INS_CHK;
                        end
                    end
                    K_INSERT_AT: begin
                        if (stat.empty) begin
                            cmd.tgt_op = TGT_ZERO;
                            cmd.idx_op = IDX_FILL;
                            state_next = S_INS_CHK;
                        end else if (stat.badpos_ins) begin
                            cmd.code = ST_BADPOS;
                        end else if (stat.full) begin
                            cmd.code = ST_FULL;
                        end else begin
                            cmd.tgt_op = TGT_POS;
                            cmd.idx_op = IDX_FILL;
                            state_next = S_INS_CHK;
                        end
                    end
                    K_DEL_LAST: begin
                        if (stat.empty) begin
                            cmd.code = ST_EMPTY;
                        end else begin
                            cmd.fill_op = FILL_DEC;
                        end
                    end
                    K_DEL_FIRST: begin
                        if (stat.empty) begin
                            cmd.code = ST_EMPTY;
                        end else begin
                            cmd.idx_op = IDX_ZERO;
                            state_next = S_REM_CHK;
                        end
                    end
                    K_DEL_AT: begin
                        if (stat.empty) begin
                            cmd.code = ST_EMPTY;
                        end else if (stat.badpos_del) begin
                            cmd.code = ST_BADPOS;
                        end else begin
                            cmd.idx_op = IDX_POS;
                            state_next = S_REM_CHK;
                        end
                    end
                    K_DEL_VALUE, K_SEARCH, K_DUMP: begin
                        if (stat.empty) begin
                            cmd.code = ST_EMPTY;
                        end else begin
                            cmd.idx_op   = IDX_ZERO;
                            cmd.pend_clr = 1'b1;
                            cmd.nres_clr = 1'b1;
                            state_next = (stat.kind == K_DEL_VALUE) ? S_DV_RD :
                                         (stat.kind == K_SEARCH) ? S_SR_RD : S_DP_RD;
                        end
                    end
                    default: ;
                endcase
            end
            S_RESP: begin
                if (stat.out_free) begin
                    cmd.emit      = EM_CODE;
                    cmd.emit_last = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            // Insert: move entries up one place from the top down to the target.
            S_INS_CHK: begin
                if (stat.idx_gt_tgt) begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_sel = RD_PREV;
                    state_next = S_INS_WR;
                end else begin
                    cmd.wr_en    = 1'b1;
                    cmd.wr_sel   = WR_NEW;
                    cmd.fill_op  = FILL_INC;
                    cmd.set_code = 1'b1;
                    state_next   = S_RESP;
                end
            end
            S_INS_WR: begin
                cmd.wr_en  = 1'b1;
                cmd.idx_op = IDX_DEC;
                state_next = S_INS_CHK;
            end
            // Remove: move entries down one place from the hole to the end.
            S_REM_CHK: begin
                if (stat.rem_more) begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_sel = RD_NEXT;
                    state_next = S_REM_WR;
                end else begin
                    cmd.fill_op  = FILL_DEC;
                    cmd.set_code = 1'b1;
                    state_next   = S_RESP;
                end
            end
            S_REM_WR: begin
                cmd.wr_en  = 1'b1;
                cmd.idx_op = IDX_INC;
                state_next = S_REM_CHK;
            end
            S_DV_RD: begin
                if (stat.idx_at_end) begin
                    cmd.set_code = 1'b1;
                    cmd.code     = ST_NOTFOUND;
                    state_next   = S_RESP;
                end else begin
                    cmd.rd_en  = 1'b1;
                    state_next = S_DV_CMP;
                end
            end
            S_DV_CMP: begin
                if (stat.match) begin
                    state_next = S_REM_CHK;
                end else begin
                    cmd.idx_op = IDX_INC;
                    state_next = S_DV_RD;
                end
            end
            // Search holds one match back so that the final one can carry last.
            S_SR_RD: begin
                if (stat.idx_at_end) begin
                    if (stat.pend_valid) begin
                        state_next = S_SR_FIN;
                    end else begin
                        cmd.set_code = 1'b1;
                        cmd.code     = ST_NOTFOUND;
                        state_next   = S_RESP;
                    end
                end else begin
                    cmd.rd_en  = 1'b1;
                    state_next = S_SR_CMP;
                end
            end
            S_SR_CMP: begin
                if (!stat.match) begin
                    cmd.idx_op = IDX_INC;
                    state_next = S_SR_RD;
                end else if (!stat.pend_valid) begin
                    cmd.pend_set = 1'b1;
                    cmd.idx_op   = IDX_INC;
                    state_next   = S_SR_RD;
                end else if (stat.out_free) begin
                    cmd.emit      = EM_PEND;
                    cmd.emit_last = stat.cap;
                    if (stat.cap) begin
                        state_next = S_IDLE;
                    end else begin
                        cmd.pend_set = 1'b1;
                        cmd.idx_op   = IDX_INC;
                        state_next   = S_SR_RD;
                    end
                end
            end
            S_SR_FIN: begin
                if (stat.out_free) begin
                    cmd.emit      = EM_PEND;
                    cmd.emit_last = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            S_DP_RD: begin
                cmd.rd_en  = 1'b1;
                state_next = S_DP_OUT;
            end
            S_DP_OUT: begin
                if (stat.out_free) begin
                    cmd.emit      = EM_DUMP;
                    cmd.emit_last = stat.dump_end;
                    if (stat.dump_end) begin
                        state_next = S_IDLE;
                    end else begin
                        cmd.idx_op = IDX_INC;
                        state_next = S_DP_RD;
                    end
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

endmodule
